/* rtl/core/hhwf_pkg.sv */
// Shared constants, register codes and divider types of the HSV hue weight filter.
package hhwf_pkg;

  localparam int HUE_W          = 8;
  localparam int SAT_W          = 8;
  localparam int VAL_W          = 8;
  localparam int WEIGHT_W       = 8;
  localparam int TOL_W          = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;
  localparam int NUM_W          = TOL_W + WEIGHT_W;
  localparam int QUO_W          = WEIGHT_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
  localparam int N_STAGES       = DIV_STAGES + 3;
  localparam int FLIGHT_W       = $clog2(N_STAGES + 1) + 1;
  localparam int SHIFT_W        = $clog2(QUO_W);

  localparam logic [HUE_W-1:0]    HUE_MAX     = HUE_W'(179);
  localparam logic [HUE_W-1:0]    HUE_SPAN    = HUE_W'(180);
  localparam logic [WEIGHT_W-1:0] FULL_WEIGHT = WEIGHT_W'(255);

  localparam logic [HUE_W-1:0] RST_HUE_CENTER    = HUE_W'(120);
  localparam logic [TOL_W-1:0] RST_HUE_TOLERANCE = TOL_W'(20);
  localparam logic [VAL_W-1:0] RST_MIN_VALUE     = VAL_W'(50);
  localparam logic [SAT_W-1:0] RST_MIN_SAT       = SAT_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_CENTER    = 3'd0,
    CFG_HUE_TOLERANCE = 3'd1,
    CFG_MIN_VALUE     = 3'd2,
    CFG_MIN_SAT       = 3'd3,
    CFG_IGNORE_HUE    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [TOL_W-1:0] tol;
    logic             full;
    logic             use_q;
  } div_t;

  // Two restoring division steps, producing quotient bits top and top-1.
  function automatic div_t div_step(input div_t src, input logic [SHIFT_W-1:0] top);
    div_t             res;
    logic [NUM_W-1:0] trial;
    logic [SHIFT_W-1:0] sh;
    res = src;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      sh    = top - SHIFT_W'(k);
      trial = {{(NUM_W-TOL_W){1'b0}}, res.tol} << sh;
      if (res.rem >= trial) begin
        res.rem     = res.rem - trial;
        res.quo[sh] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

/* rtl/core/hhwf_pix_if.sv */
// Pixel input channel: valid/ready handshake with the HSV fields.
interface hhwf_pix_if;
  logic                         valid;
  logic                         ready;
  logic [hhwf_pkg::HUE_W-1:0]   hue;
  logic [hhwf_pkg::SAT_W-1:0]   saturation;
  logic [hhwf_pkg::VAL_W-1:0]   brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

/* rtl/core/hhwf_wgt_if.sv */
// Weight result channel: valid/ready handshake with the match weight.
interface hhwf_wgt_if;
  logic                           valid;
  logic                           ready;
  logic [hhwf_pkg::WEIGHT_W-1:0]  weight;

  modport source (output valid, output weight, input ready);
  modport sink (input valid, input weight, output ready);
endinterface

/* rtl/core/hsv_hue_weight_filter.sv */
// HSV hue weight filter: threshold tests, circular hue distance and a pipelined divider.
// The filter takes one pixel every clock while the output is not stalled and gives one
// weight per pixel, in order. Two stages find the hue distance and the scaled numerator;
// a divider of four stages, two quotient bits each, forms floor(255*(tol-d)/tol); a final
// register holds the weight. Every stage holds its item while the stage after it is full
// and stalled, so back-pressure costs no data.
// Configuration writes are expected only while no pixel is in flight.
module hsv_hue_weight_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  hhwf_pix_if.sink                          in_ch,
  hhwf_wgt_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [hhwf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hhwf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  logic [hhwf_pkg::HUE_W-1:0] hue_center_r, hue_center_nxt;
  logic [hhwf_pkg::TOL_W-1:0] hue_tol_r, hue_tol_nxt;
  logic [hhwf_pkg::VAL_W-1:0] min_val_r, min_val_nxt;
  logic [hhwf_pkg::SAT_W-1:0] min_sat_r, min_sat_nxt;
  logic                       ign_hue_r, ign_hue_nxt;

  always_comb begin
    hue_center_nxt = hue_center_r;
    hue_tol_nxt    = hue_tol_r;
    min_val_nxt    = min_val_r;
    min_sat_nxt    = min_sat_r;
    ign_hue_nxt    = ign_hue_r;
    if (cfg_we) begin
      case (hhwf_pkg::cfg_reg_t'(cfg_index))
        hhwf_pkg::CFG_HUE_CENTER:    hue_center_nxt = cfg_wdata[hhwf_pkg::HUE_W-1:0];
        hhwf_pkg::CFG_HUE_TOLERANCE: hue_tol_nxt    = cfg_wdata[hhwf_pkg::TOL_W-1:0];
        hhwf_pkg::CFG_MIN_VALUE:     min_val_nxt    = cfg_wdata[hhwf_pkg::VAL_W-1:0];
        hhwf_pkg::CFG_MIN_SAT:       min_sat_nxt    = cfg_wdata[hhwf_pkg::SAT_W-1:0];
        hhwf_pkg::CFG_IGNORE_HUE:    ign_hue_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_center_r <= hhwf_pkg::RST_HUE_CENTER;
      hue_tol_r    <= hhwf_pkg::RST_HUE_TOLERANCE;
      min_val_r    <= hhwf_pkg::RST_MIN_VALUE;
      min_sat_r    <= hhwf_pkg::RST_MIN_SAT;
      ign_hue_r    <= 1'b0;
    end else begin
      hue_center_r <= hue_center_nxt;
      hue_tol_r    <= hue_tol_nxt;
      min_val_r    <= min_val_nxt;
      min_sat_r    <= min_sat_nxt;
      ign_hue_r    <= ign_hue_nxt;
    end
  end

  // Ready chain: a stage takes a new item when it is empty or its item moves on.
  logic s1_rdy, s2_rdy, out_rdy;
  logic dv_rdy [hhwf_pkg::DIV_STAGES];

  // Stage 1: saturate the hues, take the plain difference and the threshold tests.
  logic                       s1_v_r;
  logic [hhwf_pkg::HUE_W-1:0] s1_diff_r, s1_diff_nxt;
  logic [hhwf_pkg::TOL_W-1:0] s1_tol_r;
  logic                       s1_pass_r, s1_pass_nxt;
  logic                       s1_ign_r;
  logic [hhwf_pkg::HUE_W-1:0] hue_sat, ctr_sat;

  always_comb begin
    hue_sat = (in_ch.hue > hhwf_pkg::HUE_MAX) ? hhwf_pkg::HUE_MAX : in_ch.hue;
    ctr_sat = (hue_center_r > hhwf_pkg::HUE_MAX) ? hhwf_pkg::HUE_MAX : hue_center_r;
    s1_diff_nxt = (hue_sat > ctr_sat) ? (hue_sat - ctr_sat) : (ctr_sat - hue_sat);
    s1_pass_nxt = (in_ch.brightness >= min_val_r) && (in_ch.saturation >= min_sat_r);
  end

  assign s1_rdy      = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_diff_r <= s1_diff_nxt;
      s1_pass_r <= s1_pass_nxt;
      s1_ign_r  <= ign_hue_r;
      s1_tol_r  <= hue_tol_r;
    end
  end

  // Stage 2: circular distance, hit test and the numerator 255*(tol-d).
  logic                       s2_v_r;
  hhwf_pkg::div_t             s2_r, s2_nxt;
  logic [hhwf_pkg::HUE_W-1:0] wrap, hue_dist;
  logic [hhwf_pkg::TOL_W-1:0] gap;
  logic                       hit;

  always_comb begin
    wrap     = hhwf_pkg::HUE_SPAN - s1_diff_r;
    hue_dist = (s1_diff_r < wrap) ? s1_diff_r : wrap;
    hit      = hue_dist < s1_tol_r;
    gap      = s1_tol_r - hue_dist;
    s2_nxt.rem   = {gap, {hhwf_pkg::WEIGHT_W{1'b0}}}
                 - {{hhwf_pkg::WEIGHT_W{1'b0}}, gap};
    s2_nxt.quo   = '0;
    s2_nxt.tol   = s1_tol_r;
    s2_nxt.full  = s1_pass_r && s1_ign_r;
    s2_nxt.use_q = s1_pass_r && !s1_ign_r && hit;
  end

  assign s2_rdy = !s2_v_r || dv_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_r <= s2_nxt;
    end
  end

  // Divider stages, most significant quotient bits first.
  logic           dv_v_r [hhwf_pkg::DIV_STAGES];
  hhwf_pkg::div_t dv_r   [hhwf_pkg::DIV_STAGES];
  hhwf_pkg::div_t dv_nxt [hhwf_pkg::DIV_STAGES];

  for (genvar j = 0; j < hhwf_pkg::DIV_STAGES; j++) begin : g_div
    hhwf_pkg::div_t src;
    logic           src_v;
    logic           nxt_rdy;

    if (j == 0) begin : g_first
      assign src   = s2_r;
      assign src_v = s2_v_r;
    end else begin : g_rest
      assign src   = dv_r[j-1];
      assign src_v = dv_v_r[j-1];
    end

    if (j == hhwf_pkg::DIV_STAGES - 1) begin : g_last
      assign nxt_rdy = out_rdy;
    end else begin : g_mid
      assign nxt_rdy = dv_rdy[j+1];
    end

    assign dv_rdy[j] = !dv_v_r[j] || nxt_rdy;
    assign dv_nxt[j] = hhwf_pkg::div_step(src,
        hhwf_pkg::SHIFT_W'(hhwf_pkg::QUO_W - 1 - hhwf_pkg::BITS_PER_STAGE * j));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (dv_rdy[j]) begin
        dv_v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (dv_rdy[j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Output register.
  logic                          out_v_r;
  logic [hhwf_pkg::WEIGHT_W-1:0] weight_r, weight_nxt;
  hhwf_pkg::div_t                dv_last;

  assign dv_last = dv_r[hhwf_pkg::DIV_STAGES-1];

  always_comb begin
    if (dv_last.full) begin
      weight_nxt = hhwf_pkg::FULL_WEIGHT;
    end else if (dv_last.use_q) begin
      weight_nxt = dv_last.quo;
    end else begin
      weight_nxt = '0;
    end
  end

  assign out_rdy = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= dv_v_r[hhwf_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      weight_r <= weight_nxt;
    end
  end

  assign out_ch.valid  = out_v_r;
  assign out_ch.weight = weight_r;

endmodule

/* rtl/core/hhwf_checker.sv */
// Port-level checker for the HSV hue weight filter and its bind to the top level.
module hhwf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [hhwf_pkg::WEIGHT_W-1:0]     weight
);

  logic [hhwf_pkg::FLIGHT_W-1:0] in_flight_r, in_flight_nxt;

  always_comb begin
    in_flight_nxt = in_flight_r;
    if (in_valid && in_ready) begin
      in_flight_nxt = in_flight_nxt + hhwf_pkg::FLIGHT_W'(1);
    end
    if (out_valid && out_ready) begin
      in_flight_nxt = in_flight_nxt - hhwf_pkg::FLIGHT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= '0;
    end else begin
      in_flight_r <= in_flight_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(weight))
    else $error("weight changed or vanished while stalled");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input not ready although the output drains");

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_flight_r != '0)
    else $error("weight offered with no pixel in flight");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight_r <= hhwf_pkg::FLIGHT_W'(hhwf_pkg::N_STAGES))
    else $error("more pixels in flight than pipeline stages");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("weight offered straight after reset");

endmodule

bind hsv_hue_weight_filter hhwf_checker u_hhwf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .weight    (out_ch.weight)
);
